FILE: rtl/arp_request_responder_macros.svh
// assertion macros shared by the arp responder checker
// expects clk_i and rst_ni in the scope of each use
`ifndef ARP_REQUEST_RESPONDER_MACROS_SVH
`define ARP_REQUEST_RESPONDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ARP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ARP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/arp_pkg.sv
// shared types, constants and the reply byte function of the arp responder
// no dependencies
`default_nettype none

package arp_pkg;

  localparam int unsigned ReplyLen = 42;
  localparam int unsigned IdxW     = 6;

  localparam logic [IdxW-1:0] ReplyLastIdx = IdxW'(ReplyLen - 1);
  localparam logic [IdxW-1:0] FrameMinLen  = IdxW'(ReplyLen);

  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] ArpOpRequest = 16'h0001;
  localparam logic [15:0] ArpOpReply   = 16'h0002;
  localparam logic [15:0] HwTypeEth    = 16'h0001;
  localparam logic [15:0] ProtoIpv4    = 16'h0800;
  localparam logic [7:0]  HwAddrLen    = 8'h06;
  localparam logic [7:0]  ProtoAddrLen = 8'h04;

  localparam logic [47:0] OwnMacReset   = 48'h0800_27CB_802A;
  localparam logic [31:0] OwnIpReset    = 32'hC0A8_0001;
  localparam logic [31:0] ClientIpReset = 32'hC0A8_000A;

  typedef enum logic [1:0] {
    CFG_OWN_MAC   = 2'd0,
    CFG_OWN_IP    = 2'd1,
    CFG_CLIENT_IP = 2'd2
  } arp_cfg_idx_e;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] client_ip;
  } arp_cfg_t;

  // request seen: start a reply with these addresses
  typedef struct packed {
    logic        start;
    logic [47:0] dst_mac;
    logic [47:0] tgt_mac;
  } arp_start_t;

  function automatic logic [7:0] pick48(input logic [47:0] v, input logic [2:0] k);
    logic [47:0] sh;
    sh = v >> {(3'd5 - k), 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [7:0] pick32(input logic [31:0] v, input logic [1:0] k);
    logic [31:0] sh;
    sh = v >> {(2'd3 - k), 3'b000};
    return sh[7:0];
  endfunction

  // byte i of the reply frame, wire order
  function automatic logic [7:0] reply_byte_at(
    input logic [IdxW-1:0] i,
    input logic [47:0]     dst_mac,
    input logic [47:0]     tgt_mac,
    input arp_cfg_t        cfg
  );
    logic [7:0]      b;
    logic [IdxW-1:0] k;
    b = 8'h00;
    k = '0;
    if (i < IdxW'(6)) begin
      b = pick48(dst_mac, i[2:0]);
    end else if (i < IdxW'(12)) begin
      k = i - IdxW'(6);
      b = pick48(cfg.own_mac, k[2:0]);
    end else if (i < IdxW'(22)) begin
      case (i)
        IdxW'(12): b = EtherTypeArp[15:8];
        IdxW'(13): b = EtherTypeArp[7:0];
        IdxW'(14): b = HwTypeEth[15:8];
        IdxW'(15): b = HwTypeEth[7:0];
        IdxW'(16): b = ProtoIpv4[15:8];
        IdxW'(17): b = ProtoIpv4[7:0];
        IdxW'(18): b = HwAddrLen;
        IdxW'(19): b = ProtoAddrLen;
        IdxW'(20): b = ArpOpReply[15:8];
        IdxW'(21): b = ArpOpReply[7:0];
        default:   b = 8'h00;
      endcase
    end else if (i < IdxW'(28)) begin
      k = i - IdxW'(22);
      b = pick48(cfg.own_mac, k[2:0]);
    end else if (i < IdxW'(32)) begin
      k = i - IdxW'(28);
      b = pick32(cfg.own_ip, k[1:0]);
    end else if (i < IdxW'(38)) begin
      k = i - IdxW'(32);
      b = pick48(tgt_mac, k[2:0]);
    end else begin
      k = i - IdxW'(38);
      b = pick32(cfg.client_ip, k[1:0]);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/arp_cfg_regs.sv
// configuration register file: own mac, own ip, client ip
// depends on arp_pkg
`default_nettype none

module arp_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [47:0]   cfg_data_i,
  output arp_pkg::arp_cfg_t  cfg_o
);
  import arp_pkg::*;

  arp_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_mac   <= OwnMacReset;
      cfg_q.own_ip    <= OwnIpReset;
      cfg_q.client_ip <= ClientIpReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OWN_MAC:   cfg_q.own_mac   <= cfg_data_i;
        CFG_OWN_IP:    cfg_q.own_ip    <= cfg_data_i[31:0];
        CFG_CLIENT_IP: cfg_q.client_ip <= cfg_data_i[31:0];
        default:       ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/arp_frame_parser.sv
// receive side: byte counter, header field capture, request detection
// depends on arp_pkg
`default_nettype none

module arp_frame_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           beat_i,
  input  wire logic [7:0]     frame_byte_i,
  input  wire logic           frame_last_i,
  output arp_pkg::arp_start_t start_o
);
  import arp_pkg::*;

  logic [IdxW-1:0] idx_q;
  logic [47:0]     src_mac_q;
  logic [15:0]     ether_kind_q;
  logic [15:0]     arp_op_q;
  logic [47:0]     req_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      src_mac_q    <= '0;
      ether_kind_q <= '0;
      arp_op_q     <= '0;
      req_mac_q    <= '0;
    end else if (beat_i) begin
      if (idx_q >= IdxW'(6) && idx_q < IdxW'(12)) begin
        src_mac_q <= {src_mac_q[39:0], frame_byte_i};
      end else if (idx_q >= IdxW'(12) && idx_q < IdxW'(14)) begin
        ether_kind_q <= {ether_kind_q[7:0], frame_byte_i};
      end else if (idx_q >= IdxW'(20) && idx_q < IdxW'(22)) begin
        arp_op_q <= {arp_op_q[7:0], frame_byte_i};
      end else if (idx_q >= IdxW'(22) && idx_q < IdxW'(28)) begin
        req_mac_q <= {req_mac_q[39:0], frame_byte_i};
      end
      if (frame_last_i) begin
        idx_q <= '0;
      end else if (idx_q < FrameMinLen) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // fields are complete long before the 42nd byte, so the held values decide
  always_comb begin
    start_o.start   = beat_i && frame_last_i && (idx_q >= ReplyLastIdx) &&
                      (ether_kind_q == EtherTypeArp) && (arp_op_q == ArpOpRequest);
    start_o.dst_mac = (req_mac_q != '0) ? req_mac_q : src_mac_q;
    start_o.tgt_mac = req_mac_q;
  end

endmodule

`default_nettype wire

FILE: rtl/arp_reply_gen.sv
// transmit side: reply byte sequencer with an output register
// depends on arp_pkg
`default_nettype none

module arp_reply_gen (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  arp_pkg::arp_start_t start_i,
  input  arp_pkg::arp_cfg_t   cfg_i,
  output logic                busy_o,
  output logic                reply_valid_o,
  input  wire logic           reply_stall_i,
  output logic [7:0]          reply_byte_o,
  output logic                reply_last_o
);
  import arp_pkg::*;

  logic            pend_q;
  logic [IdxW-1:0] idx_q;
  logic [47:0]     dst_q;
  logic [47:0]     tgt_q;
  logic            ov_q;
  logic [7:0]      ob_q;
  logic            ol_q;
  logic            load;

  assign load          = pend_q && (!ov_q || !reply_stall_i);
  assign busy_o        = pend_q;
  assign reply_valid_o = ov_q;
  assign reply_byte_o  = ob_q;
  assign reply_last_o  = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (start_i.start) begin
        pend_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        idx_q <= idx_q + IdxW'(1);
        if (idx_q == ReplyLastIdx) begin
          pend_q <= 1'b0;
        end
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (!reply_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.start) begin
      dst_q <= start_i.dst_mac;
      tgt_q <= start_i.tgt_mac;
    end
    if (load) begin
      ob_q <= reply_byte_at(idx_q, dst_q, tgt_q, cfg_i);
      ol_q <= (idx_q == ReplyLastIdx);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/arp_request_responder.sv
// top level of the arp request responder
// depends on arp_pkg, arp_cfg_regs, arp_frame_parser, arp_reply_gen
`default_nettype none

// Answers ARP requests seen in a received Ethernet frame. Frame bytes come in
// one beat per cycle on the frame channel with a last flag; the block keeps the
// source MAC, EtherType, opcode and sender MAC as they pass. On the last beat of
// a frame of at least 42 bytes carrying an ARP request it sends a 42-byte ARP
// reply on the reply channel, one byte per beat, reply_last_o on the final one.
// The reply goes to the request's sender MAC, or to the frame's source MAC when
// the sender MAC is zero, and carries own_mac, own_ip and client_ip from the
// config port. Rate: frame beats are taken back to back except as below, and
// a reply streams out at one byte per cycle unless the sink stalls. The reply
// sequencer holds one reply at a time, so the last beat of a frame is stalled
// while an earlier reply still has bytes left to load; all other beats pass
// without stall. The output register lets the next frame stream in while reply
// bytes wait for the sink. Config writes are never held off (ready is always
// high) and must only happen while no reply is in flight.

module arp_request_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received frame
  input  wire logic        frame_valid_i,
  output logic             frame_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  // reply frame
  output logic             reply_valid_o,
  input  wire logic        reply_stall_i,
  output logic [7:0]       reply_byte_o,
  output logic             reply_last_o,
  // config writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);
  import arp_pkg::*;

  arp_cfg_t   cfg;
  arp_start_t start;
  logic       gen_busy;
  logic       frame_beat;

  // only a closing beat can start a reply, so only that one waits
  assign frame_stall_o = gen_busy && frame_last_i;
  assign frame_beat    = frame_valid_i && !frame_stall_o;

  arp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  arp_frame_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (frame_beat),
    .frame_byte_i (frame_byte_i),
    .frame_last_i (frame_last_i),
    .start_o      (start)
  );

  arp_reply_gen u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .cfg_i         (cfg),
    .busy_o        (gen_busy),
    .reply_valid_o (reply_valid_o),
    .reply_stall_i (reply_stall_i),
    .reply_byte_o  (reply_byte_o),
    .reply_last_o  (reply_last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/arp_checker.sv
// port-level checks for arp_request_responder, attached by bind
// depends on arp_request_responder_macros.svh
`default_nettype none

`include "arp_request_responder_macros.svh"

module arp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        frame_stall_o,
  input wire logic        frame_last_i,
  input wire logic        reply_valid_o,
  input wire logic        reply_stall_i,
  input wire logic [7:0]  reply_byte_o,
  input wire logic        reply_last_o
);

  // a stalled reply beat holds its payload
  `ARP_ASSERT_NEXT(a_reply_hold, reply_valid_o && reply_stall_i,
    reply_valid_o && $stable(reply_byte_o) && $stable(reply_last_o),
    "reply beat changed while stalled")

  // only the closing beat of a frame is ever held back
  `ARP_ASSERT_NOW(a_stall_last_only, frame_stall_o, frame_last_i,
    "frame stall on a beat that is not the last")

  // reply bytes follow each other without gaps until the last one
  `ARP_ASSERT_NEXT(a_reply_gapless, reply_valid_o && !reply_stall_i && !reply_last_o,
    reply_valid_o, "gap inside a reply frame")

endmodule

bind arp_request_responder arp_checker u_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// self-checking bench for arp_request_responder: random and directed frames in,
// reply beats checked against an in-bench reply predictor
// depends on arp_pkg and the rtl of arp_request_responder

module tb;
  import arp_pkg::*;

  // one beat on either byte stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // spare code on the config index, the block must ignore it
  localparam logic [1:0] CfgIdxUnused = 2'd3;

  localparam int unsigned HoldoffCycles = 240;   // long sink hold-off
  localparam int unsigned WatchdogLimit = 3000;  // cycles with no beat anywhere
  localparam int unsigned SettleCycles  = 40;    // quiet time before config writes
  localparam int unsigned PhaseBytes    = 70;    // random frame bytes per phase

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        frame_valid = 1'b0;
  logic        frame_stall;
  logic [7:0]  frame_byte  = '0;
  logic        frame_last  = 1'b0;

  logic        reply_valid;
  logic        reply_stall = 1'b0;
  logic [7:0]  reply_byte;
  logic        reply_last;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data  = '0;

  // frame beats still to offer, reply beats still owed by the block
  beat_t       frames_to_send[$];
  beat_t       reply_beats_due[$];

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  // long hold-off handshake between the sequence and the stall process
  logic        holdoff_req  = 1'b0;
  logic        holdoff_seen = 1'b0;
  int unsigned holdoff_left = 0;

  // predictor copy of the block state and its registers
  logic [5:0]  rx_count;
  logic [47:0] rx_eth_src;
  logic [15:0] rx_ether_kind;
  logic [15:0] rx_oper;
  logic [47:0] rx_sender_mac;
  arp_cfg_t    cfg_shadow;

  arp_request_responder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_stall_o (frame_stall),
    .frame_byte_i  (frame_byte),
    .frame_last_i  (frame_last),
    .reply_valid_o (reply_valid),
    .reply_stall_i (reply_stall),
    .reply_byte_o  (reply_byte),
    .reply_last_o  (reply_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // fold one accepted frame beat into the predictor, queue the reply it earns
  task automatic absorb_frame_beat(input logic [7:0] b, input logic is_last);
    logic [47:0]  dst;
    logic [335:0] reply_img;
    // capture windows follow the wire layout of an arp frame
    if (rx_count >= 6 && rx_count < 12) rx_eth_src = {rx_eth_src[39:0], b};
    else if (rx_count >= 12 && rx_count < 14) rx_ether_kind = {rx_ether_kind[7:0], b};
    else if (rx_count >= 20 && rx_count < 22) rx_oper = {rx_oper[7:0], b};
    else if (rx_count >= 22 && rx_count < 28) rx_sender_mac = {rx_sender_mac[39:0], b};
    // count saturates once a full arp frame has been seen
    if (rx_count < FrameMinLen) rx_count = rx_count + 6'd1;
    if (is_last) begin
      if (rx_count == FrameMinLen && rx_ether_kind == EtherTypeArp &&
          rx_oper == ArpOpRequest) begin
        // zero sender mac: answer the ethernet source instead
        dst = (rx_sender_mac != '0) ? rx_sender_mac : rx_eth_src;
        reply_img = {dst, cfg_shadow.own_mac, EtherTypeArp, HwTypeEth, ProtoIpv4,
                     HwAddrLen, ProtoAddrLen, ArpOpReply, cfg_shadow.own_mac,
                     cfg_shadow.own_ip, rx_sender_mac, cfg_shadow.client_ip};
        for (int unsigned i = 0; i < ReplyLen; i++)
          reply_beats_due.push_back('{data: reply_img[335 - 8*i -: 8],
                                      last: (i == ReplyLen - 1)});
      end
      rx_count = '0;
    end
  endtask

  // frame feeder: holds a beat until taken, then maybe idles
  always @(posedge clk_i) begin : feed_frames
    logic  offering;
    beat_t nxt;
    if (!rst_ni) begin
      frame_valid <= 1'b0;
    end else begin
      offering = frame_valid;
      if (frame_valid && !frame_stall) begin
        absorb_frame_beat(frame_byte, frame_last);
        offering = 1'b0;
      end
      if (!offering) begin
        if (frames_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = frames_to_send.pop_front();
          frame_valid <= 1'b1;
          frame_byte  <= nxt.data;
          frame_last  <= nxt.last;
        end else begin
          frame_valid <= 1'b0;
        end
      end
    end
  end

  // sink stall: random, or a counted hold-off when the sequence asks for one
  always @(posedge clk_i) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HoldoffCycles;
      reply_stall  <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      reply_stall  <= 1'b1;
    end else begin
      reply_stall  <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // reply checker: every taken beat against the oldest owed beat
  always @(posedge clk_i) begin : check_reply
    beat_t due;
    if (rst_ni && reply_valid && !reply_stall) begin
      if (reply_beats_due.size() == 0) begin
        $display("%0t: reply beat with none owed, got byte %02h last %0b",
                 $time, reply_byte, reply_last);
        mismatches++;
      end else begin
        due = reply_beats_due.pop_front();
        if (reply_byte !== due.data) begin
          $display("%0t: reply byte expected %02h got %02h", $time, due.data, reply_byte);
          mismatches++;
        end
        if (reply_last !== due.last) begin
          $display("%0t: reply last expected %0b got %0b", $time, due.last, reply_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without a beat on any channel ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_valid && !frame_stall) || (reply_valid && !reply_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one register write, shadow follows once the beat is taken
  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_MAC:   cfg_shadow.own_mac   = val;
      CFG_OWN_IP:    cfg_shadow.own_ip    = val[31:0];
      CFG_CLIENT_IP: cfg_shadow.client_ip = val[31:0];
      default: ;
    endcase
  endtask

  task automatic write_random_config();
    write_reg(CFG_OWN_MAC, rand_mac());
    write_reg(CFG_OWN_IP, rand_mac());
    write_reg(CFG_CLIENT_IP, rand_mac());
  endtask

  // lay out one frame: arp header fields, then random padding past 42 bytes
  task automatic queue_frame(input logic [47:0] dst, input logic [47:0] src,
                             input logic [15:0] etype, input logic [15:0] oper,
                             input logic [47:0] sha, input int unsigned len);
    logic [335:0] hdr;
    logic [7:0]   b;
    hdr = {dst, src, etype, HwTypeEth, ProtoIpv4, HwAddrLen, ProtoAddrLen, oper, sha,
           32'($urandom), rand_mac(), 32'($urandom)};
    for (int unsigned i = 0; i < len; i++) begin
      b = (i < ReplyLen) ? hdr[335 - 8*i -: 8] : 8'($urandom);
      frames_to_send.push_back('{data: b, last: (i == len - 1)});
    end
  endtask

  // mostly well-formed requests, the rest broken or short
  task automatic queue_random_frame(inout int unsigned sent);
    int unsigned roll;
    int unsigned len;
    logic [15:0] etype;
    logic [15:0] oper;
    logic [47:0] sha;
    roll  = $urandom_range(99);
    len   = ($urandom_range(7) == 0) ? $urandom_range(ReplyLen + 1, 80) : ReplyLen;
    etype = EtherTypeArp;
    oper  = ArpOpRequest;
    sha   = rand_mac();
    if (roll < 10) sha = '0;
    else if (roll >= 76 && roll < 82) etype = 16'($urandom);
    else if (roll >= 82 && roll < 88) oper = $urandom_range(1) ? ArpOpReply : 16'($urandom);
    else if (roll >= 88) len = $urandom_range(1, ReplyLen - 1);
    queue_frame(rand_mac(), rand_mac(), etype, oper, sha, len);
    sent += len;
  endtask

  // wait until every frame beat is taken and every reply beat has come back
  task automatic wait_until_drained();
    while (frames_to_send.size() != 0 || frame_valid || reply_beats_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    sent = 0;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    while (sent < PhaseBytes) queue_random_frame(sent);
    wait_until_drained();
  endtask

  initial begin
    rx_count      = '0;
    rx_eth_src    = '0;
    rx_ether_kind = '0;
    rx_oper       = '0;
    rx_sender_mac = '0;
    cfg_shadow    = '{own_mac: OwnMacReset, own_ip: OwnIpReset, client_ip: ClientIpReset};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames on reset register values
    queue_frame('1, '1, EtherTypeArp, ArpOpRequest, '1, ReplyLen);         // all-ones addresses
    queue_frame('1, rand_mac(), EtherTypeArp, ArpOpRequest, '0, ReplyLen); // zero sender mac
    queue_frame('1, '0, EtherTypeArp, ArpOpRequest, '0, ReplyLen);         // both macs zero
    queue_frame('1, rand_mac(), EtherTypeArp, ArpOpRequest, rand_mac(), ReplyLen - 1); // short
    queue_frame('1, rand_mac(), EtherTypeArp, ArpOpRequest, rand_mac(), 1); // single beat
    queue_frame('1, rand_mac(), ProtoIpv4, ArpOpRequest, rand_mac(), ReplyLen); // not arp
    queue_frame('1, rand_mac(), EtherTypeArp, ArpOpReply, rand_mac(), ReplyLen); // arp reply
    queue_frame('0, rand_mac(), EtherTypeArp, ArpOpRequest, rand_mac(), 70); // long, count saturates
    wait_until_drained();

    // extremes, plus a write to the unused index that must change nothing
    write_reg(CFG_OWN_MAC, '1);
    write_reg(CFG_OWN_IP, '0);
    write_reg(CFG_CLIENT_IP, '1);
    write_reg(CfgIdxUnused, rand_mac());
    run_random_phase(0, 0);

    write_reg(CFG_OWN_MAC, '0);
    write_reg(CFG_OWN_IP, '1);
    write_reg(CFG_CLIENT_IP, '0);
    run_random_phase(46, 0);

    // sink holds off while requests keep coming: the block fills and stalls frames
    write_random_config();
    sender_idle_pct = 0;
    sink_stall_pct  = 46;
    @(posedge clk_i);
    holdoff_req <= ~holdoff_req;
    repeat (3) queue_frame(rand_mac(), rand_mac(), EtherTypeArp, ArpOpRequest, rand_mac(),
                           ReplyLen);
    wait_until_drained();
    run_random_phase(0, 46);

    write_random_config();
    run_random_phase(11, 11);

    if (mismatches == 0 && reply_beats_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
